### sv/mecanum_joystick_servo_controller_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the mecanum servo controller.
// ----------------------------------------------------------------------------
`ifndef MECANUM_JOYSTICK_SERVO_CONTROLLER_CORE_ASSERT_SVH
`define MECANUM_JOYSTICK_SERVO_CONTROLLER_CORE_ASSERT_SVH

// condition must hold at every edge out of reset
`define MJSC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// same-cycle implication
`define MJSC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MJSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/mjsc_pkg.sv
// ----------------------------------------------------------------------------
// mjsc_pkg
// Types, constants and helpers for the mecanum mixer and servo sequencer.
// ----------------------------------------------------------------------------
package mjsc_pkg;

  localparam int WHEEL_COUNT = 4;
  localparam int WHEEL_IDX_W = $clog2(WHEEL_COUNT);
  localparam int SLOT_W      = $clog2(WHEEL_COUNT + 1);
  localparam int GAP_W       = 11;
  localparam int DB_W        = 7;

  typedef logic [7:0] pulse_t;
  typedef pulse_t [WHEEL_COUNT-1:0] wheel_arr_t;
  typedef logic signed [7:0] offset_t;
  typedef logic signed [10:0] mix_t;

  typedef struct packed {
    logic [DB_W-1:0]  deadband;
    pulse_t           pulse_min;
    pulse_t           pulse_max;
    pulse_t           centre_pulse;
    logic [GAP_W-1:0] gap_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    deadband:     7'd10,
    pulse_min:    8'd125,
    pulse_max:    8'd250,
    centre_pulse: 8'd187,
    gap_ticks:    11'd1875
  };

  typedef enum logic [2:0] {
    REG_DEADBAND  = 3'd0,
    REG_PULSE_MIN = 3'd1,
    REG_PULSE_MAX = 3'd2,
    REG_CENTRE    = 3'd3,
    REG_GAP_TICKS = 3'd4
  } reg_idx_t;

  localparam logic       CMD_TICK   = 1'b1;
  localparam logic [1:0] BTN_C_ONLY = 2'd1;
  localparam logic [1:0] BTN_Z_ONLY = 2'd2;
  localparam pulse_t     BAD_ACCEL  = 8'hFF;

  localparam logic [SLOT_W-1:0] SLOT_GAP       = SLOT_W'(WHEEL_COUNT);
  localparam logic [GAP_W-1:0]  SLOT_RESET_LEN = 11'd187;
  localparam pulse_t            WHEEL_RESET    = 8'd187;

  // bit k set: that wheel takes the term negated
  localparam logic [WHEEL_COUNT-1:0] MIX_FWD_NEG  = 4'b1100;
  localparam logic [WHEEL_COUNT-1:0] MIX_SIDE_NEG = 4'b0110;

  // (s - z) / 2, truncating toward zero
  function automatic offset_t halve_offset(pulse_t s, pulse_t z);
    logic signed [8:0] d;
    d = $signed({1'b0, s}) - $signed({1'b0, z});
    d = d + $signed({8'd0, d[8]});
    return d[8:1];
  endfunction

  // low bound tested first, so it wins when the bounds cross
  function automatic pulse_t clamp_pulse(mix_t v, pulse_t lo, pulse_t hi);
    pulse_t res;
    if (v < $signed({3'b000, lo})) begin
      res = lo;
    end else if (v > $signed({3'b000, hi})) begin
      res = hi;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

### sv/mjsc_mixer.sv
// ----------------------------------------------------------------------------
// mjsc_mixer
// Stick offsets, deadband test and per-wheel mixing with signed clamp.
// ----------------------------------------------------------------------------
module mjsc_mixer (
  input  mjsc_pkg::cfg_t       cfg,
  input  mjsc_pkg::pulse_t     stick_x,
  input  mjsc_pkg::pulse_t     stick_y,
  input  mjsc_pkg::pulse_t     zero_x,
  input  mjsc_pkg::pulse_t     zero_y,
  input  logic                 rotate,
  output mjsc_pkg::wheel_arr_t wheel
);

  mjsc_pkg::offset_t           dx;
  mjsc_pkg::offset_t           dy;
  logic [mjsc_pkg::DB_W-1:0]   adx;
  logic [mjsc_pkg::DB_W-1:0]   ady;
  logic                        neutral;
  mjsc_pkg::mix_t              dx_w;
  mjsc_pkg::mix_t              dy_w;
  mjsc_pkg::mix_t              centre_w;

  always_comb begin
    dx       = mjsc_pkg::halve_offset(stick_x, zero_x);
    dy       = mjsc_pkg::halve_offset(stick_y, zero_y);
    // |offset| <= 127 after halving
    adx      = dx[7] ? mjsc_pkg::DB_W'(-dx) : dx[6:0];
    ady      = dy[7] ? mjsc_pkg::DB_W'(-dy) : dy[6:0];
    neutral  = (adx < cfg.deadband) && (ady < cfg.deadband);
    dx_w     = $signed({{3{dx[7]}}, dx});
    dy_w     = $signed({{3{dy[7]}}, dy});
    centre_w = $signed({3'b000, cfg.centre_pulse});
  end

  for (genvar k = 0; k < mjsc_pkg::WHEEL_COUNT; k++) begin : g_wheel
    mjsc_pkg::mix_t fwd_term;
    mjsc_pkg::mix_t side_term;
    mjsc_pkg::mix_t v;

    always_comb begin
      fwd_term  = mjsc_pkg::MIX_FWD_NEG[k] ? -dy_w : dy_w;
      side_term = mjsc_pkg::MIX_SIDE_NEG[k] ? -dx_w : dx_w;
      if (neutral) begin
        v = centre_w;
      end else if (rotate) begin
        v = centre_w - dx_w;
      end else begin
        v = centre_w + fwd_term + side_term;
      end
      wheel[k] = mjsc_pkg::clamp_pulse(v, cfg.pulse_min, cfg.pulse_max);
    end
  end

endmodule

### sv/mecanum_joystick_servo_controller_core.sv
// ----------------------------------------------------------------------------
// mecanum_joystick_servo_controller_core: mecanum mixer and servo sequencer
// State and result register load at input transfer; result shows the next cycle.
// Throughput 1 item per cycle; input stalls only while a held result stalls.
// Synchronous active-low reset restores config and state; result regs keep value.
// ----------------------------------------------------------------------------
module mecanum_joystick_servo_controller_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [2:0]                            cfg_index,
  input  logic [10:0]                           cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic [7:0]                            in_stick_x,
  input  logic [7:0]                            in_stick_y,
  input  logic [7:0]                            in_accel_z,
  input  logic [1:0]                            in_buttons,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [mjsc_pkg::WHEEL_COUNT-1:0]      out_servo_pins,
  output logic [7:0]                            out_wheel0_pulse,
  output logic [7:0]                            out_wheel1_pulse,
  output logic [7:0]                            out_wheel2_pulse,
  output logic [7:0]                            out_wheel3_pulse,
  output logic                                  out_running
);

  mjsc_pkg::cfg_t                       cfg_r, cfg_nxt;
  logic                                 started_r, started_nxt;
  mjsc_pkg::pulse_t                     zero_x_r, zero_x_nxt;
  mjsc_pkg::pulse_t                     zero_y_r, zero_y_nxt;
  mjsc_pkg::wheel_arr_t                 wheel_r, wheel_nxt;
  logic [mjsc_pkg::SLOT_W-1:0]          slot_idx_r, slot_idx_nxt;
  logic [mjsc_pkg::GAP_W-1:0]           slot_rem_r, slot_rem_nxt;
  logic [mjsc_pkg::WHEEL_COUNT-1:0]     pins_r, pins_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [mjsc_pkg::WHEEL_COUNT-1:0]     out_pins_r;
  mjsc_pkg::wheel_arr_t                 out_wheel_r;
  logic                                 out_running_r;

  logic                                 in_xfer;
  logic                                 c_press;
  mjsc_pkg::pulse_t                     mix_zero_x;
  mjsc_pkg::pulse_t                     mix_zero_y;
  mjsc_pkg::wheel_arr_t                 mix_wheel;
  logic [mjsc_pkg::SLOT_W-1:0]          slot_step;

  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;
  assign c_press  = (in_buttons == mjsc_pkg::BTN_C_ONLY);

  // a C press re-zeroes before mixing
  assign mix_zero_x = c_press ? in_stick_x : zero_x_r;
  assign mix_zero_y = c_press ? in_stick_y : zero_y_r;

  mjsc_mixer u_mixer (
    .cfg     (cfg_r),
    .stick_x (in_stick_x),
    .stick_y (in_stick_y),
    .zero_x  (mix_zero_x),
    .zero_y  (mix_zero_y),
    .rotate  (in_buttons == mjsc_pkg::BTN_Z_ONLY),
    .wheel   (mix_wheel)
  );

  assign slot_step = (slot_idx_r >= mjsc_pkg::SLOT_GAP) ? '0 : slot_idx_r + 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (mjsc_pkg::reg_idx_t'(cfg_index))
        mjsc_pkg::REG_DEADBAND:  cfg_nxt.deadband     = cfg_wdata[mjsc_pkg::DB_W-1:0];
        mjsc_pkg::REG_PULSE_MIN: cfg_nxt.pulse_min    = cfg_wdata[7:0];
        mjsc_pkg::REG_PULSE_MAX: cfg_nxt.pulse_max    = cfg_wdata[7:0];
        mjsc_pkg::REG_CENTRE:    cfg_nxt.centre_pulse = cfg_wdata[7:0];
        mjsc_pkg::REG_GAP_TICKS: cfg_nxt.gap_ticks    = cfg_wdata;
        default:                 cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_comb begin
    started_nxt  = started_r;
    zero_x_nxt   = zero_x_r;
    zero_y_nxt   = zero_y_r;
    wheel_nxt    = wheel_r;
    slot_idx_nxt = slot_idx_r;
    slot_rem_nxt = slot_rem_r;
    pins_nxt     = pins_r;
    if (in_xfer) begin
      if (in_cmd == mjsc_pkg::CMD_TICK) begin
        if (started_r) begin
          if (slot_rem_r > mjsc_pkg::GAP_W'(1)) begin
            slot_rem_nxt = slot_rem_r - 1'b1;
          end else begin
            slot_idx_nxt = slot_step;
            if (slot_step == mjsc_pkg::SLOT_GAP) begin
              pins_nxt     = '0;
              slot_rem_nxt = cfg_r.gap_ticks;
            end else begin
              pins_nxt     = mjsc_pkg::WHEEL_COUNT'(1) << slot_step[mjsc_pkg::WHEEL_IDX_W-1:0];
              slot_rem_nxt = {3'b000, wheel_r[slot_step[mjsc_pkg::WHEEL_IDX_W-1:0]]};
            end
          end
        end
      end else if (!started_r) begin
        // first C press only arms the block; wheels untouched
        if (c_press) begin
          zero_x_nxt  = in_stick_x;
          zero_y_nxt  = in_stick_y;
          started_nxt = 1'b1;
        end
      end else if (in_accel_z != mjsc_pkg::BAD_ACCEL) begin
        zero_x_nxt = mix_zero_x;
        zero_y_nxt = mix_zero_y;
        wheel_nxt  = mix_wheel;
      end
    end
  end

  assign out_valid_nxt = in_xfer | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= mjsc_pkg::CFG_RESET;
      started_r   <= 1'b0;
      zero_x_r    <= '0;
      zero_y_r    <= '0;
      wheel_r     <= {mjsc_pkg::WHEEL_COUNT{mjsc_pkg::WHEEL_RESET}};
      slot_idx_r  <= mjsc_pkg::SLOT_GAP;
      slot_rem_r  <= mjsc_pkg::SLOT_RESET_LEN;
      pins_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      started_r   <= started_nxt;
      zero_x_r    <= zero_x_nxt;
      zero_y_r    <= zero_y_nxt;
      wheel_r     <= wheel_nxt;
      slot_idx_r  <= slot_idx_nxt;
      slot_rem_r  <= slot_rem_nxt;
      pins_r      <= pins_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register, loaded with the post-item state
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_pins_r    <= pins_nxt;
      out_wheel_r   <= wheel_nxt;
      out_running_r <= started_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_servo_pins   = out_pins_r;
  assign out_wheel0_pulse = out_wheel_r[0];
  assign out_wheel1_pulse = out_wheel_r[1];
  assign out_wheel2_pulse = out_wheel_r[2];
  assign out_wheel3_pulse = out_wheel_r[3];
  assign out_running      = out_running_r;

endmodule

### sv/mjsc_checker.sv
// ----------------------------------------------------------------------------
// mjsc_checker
// Port-level checks on the servo controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "mecanum_joystick_servo_controller_core_assert.svh"

module mjsc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [mjsc_pkg::WHEEL_COUNT-1:0] out_servo_pins,
  input logic                             out_running
);

  // at most one wheel pulse at a time
  `MJSC_ASSERT_IMPLY(a_pins_onehot0, clk, rst_n, out_valid, $onehot0(out_servo_pins))

  // pins stay low until started
  `MJSC_ASSERT_IMPLY(a_idle_pins_low, clk, rst_n, out_valid && !out_running, out_servo_pins == '0)

  // every input transfer gives a result next cycle
  `MJSC_ASSERT_NEXT(a_xfer_result, clk, rst_n, in_valid && !in_stall, out_valid)

  // running is sticky once shown
  `MJSC_ASSERT_NEXT(a_running_sticky, clk, rst_n, out_valid && out_running, !out_valid || out_running)

  // stalled result holds
  `MJSC_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_servo_pins))

endmodule

bind mecanum_joystick_servo_controller_core mjsc_checker u_mjsc_checker (.*);

### sim/mecanum_joystick_servo_controller_core_tb.sv
// ----------------------------------------------------------------------------
// mecanum_joystick_servo_controller_core_tb
// Self-checking bench for the mecanum mixer and servo pulse sequencer. A
// shadow model of the mixer, the clamp and the five-slot sequencer predicts
// the state after every input transfer; each output transfer is checked
// against the oldest prediction. Directed start-up and mixing cases come
// first, then random traffic under several register settings, with random
// idle cycles on both channels.
// ----------------------------------------------------------------------------
module mecanum_joystick_servo_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mjsc_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int IDLE_PCT      = 23;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 3;
  localparam int TIMEOUT_NS    = 2_000_000;

  localparam logic       CMD_SAMPLE = ~CMD_TICK;
  localparam logic [1:0] BTN_BOTH   = 2'd0;
  localparam logic [1:0] BTN_NONE   = 2'd3;

  // bit k set: wheel k takes the forward / sideways term negated
  localparam logic [WHEEL_COUNT-1:0] FWD_FLIP  = 4'b1100;
  localparam logic [WHEEL_COUNT-1:0] SIDE_FLIP = 4'b0110;

  typedef struct packed {
    logic       cmd;
    pulse_t     stick_x;
    pulse_t     stick_y;
    pulse_t     accel_z;
    logic [1:0] buttons;
  } joy_item_t;

  typedef struct packed {
    logic [WHEEL_COUNT-1:0] pins;
    wheel_arr_t             wheels;
    logic                   running;
  } wheel_state_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [2:0]             cfg_index  = '0;
  logic [10:0]            cfg_wdata  = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic                   in_cmd     = 1'b0;
  logic [7:0]             in_stick_x = '0;
  logic [7:0]             in_stick_y = '0;
  logic [7:0]             in_accel_z = '0;
  logic [1:0]             in_buttons = 2'd3;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic [WHEEL_COUNT-1:0] out_servo_pins;
  logic [7:0]             out_wheel0_pulse;
  logic [7:0]             out_wheel1_pulse;
  logic [7:0]             out_wheel2_pulse;
  logic [7:0]             out_wheel3_pulse;
  logic                   out_running;

  // shadow of the block
  cfg_t                   shadow_cfg = CFG_RESET;
  logic                   armed      = 1'b0;
  pulse_t                 home_x     = '0;
  pulse_t                 home_y     = '0;
  wheel_arr_t             wheel_len  = {WHEEL_COUNT{WHEEL_RESET}};
  int unsigned            slot       = WHEEL_COUNT;
  logic [GAP_W-1:0]       slot_left  = SLOT_RESET_LEN;
  logic [WHEEL_COUNT-1:0] pins_now   = '0;

  wheel_state_t expected_wheel_state[$];
  int           mismatch_count = 0;
  bit           steady_flow    = 1'b0;

  mecanum_joystick_servo_controller_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_stick_x       (in_stick_x),
    .in_stick_y       (in_stick_y),
    .in_accel_z       (in_accel_z),
    .in_buttons       (in_buttons),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_servo_pins   (out_servo_pins),
    .out_wheel0_pulse (out_wheel0_pulse),
    .out_wheel1_pulse (out_wheel1_pulse),
    .out_wheel2_pulse (out_wheel2_pulse),
    .out_wheel3_pulse (out_wheel3_pulse),
    .out_running      (out_running)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Regression FAIL");
    $finish;
  end

  // lower bound is tested first, so it wins when the bounds cross
  function automatic pulse_t limit_pulse(int v);
    if (v < int'(shadow_cfg.pulse_min)) return shadow_cfg.pulse_min;
    if (v > int'(shadow_cfg.pulse_max)) return shadow_cfg.pulse_max;
    return pulse_t'(v);
  endfunction

  function automatic wheel_state_t predict_wheel_state(joy_item_t it);
    int           dx;
    int           dy;
    int           v;
    wheel_state_t r;
    if (it.cmd == CMD_TICK) begin
      if (armed) begin
        if (slot_left > 1) begin
          slot_left = slot_left - 1'b1;
        end else begin
          slot = (slot >= WHEEL_COUNT) ? 0 : slot + 1;
          pins_now = '0;
          if (slot == WHEEL_COUNT) begin
            slot_left = shadow_cfg.gap_ticks;
          end else begin
            pins_now[slot] = 1'b1;
            slot_left = GAP_W'(wheel_len[slot]);
          end
        end
      end
    end else if (!armed) begin
      if (it.buttons == BTN_C_ONLY) begin
        home_x = it.stick_x;
        home_y = it.stick_y;
        armed = 1'b1;
      end
    end else if (it.accel_z != BAD_ACCEL) begin
      if (it.buttons == BTN_C_ONLY) begin
        home_x = it.stick_x;
        home_y = it.stick_y;
      end
      // int division truncates toward zero
      dx = (int'(it.stick_x) - int'(home_x)) / 2;
      dy = (int'(it.stick_y) - int'(home_y)) / 2;
      for (int k = 0; k < WHEEL_COUNT; k++) begin
        if ((dx < 0 ? -dx : dx) < int'(shadow_cfg.deadband) &&
            (dy < 0 ? -dy : dy) < int'(shadow_cfg.deadband)) begin
          v = int'(shadow_cfg.centre_pulse);
        end else if (it.buttons == BTN_Z_ONLY) begin
          v = int'(shadow_cfg.centre_pulse) - dx;
        end else begin
          v = int'(shadow_cfg.centre_pulse) + (FWD_FLIP[k] ? -dy : dy)
              + (SIDE_FLIP[k] ? -dx : dx);
        end
        wheel_len[k] = limit_pulse(v);
      end
    end
    r.pins    = pins_now;
    r.wheels  = wheel_len;
    r.running = armed;
    return r;
  endfunction

  function automatic pulse_t near_home(pulse_t h, int span);
    int v;
    v = int'(h) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return pulse_t'(v);
  endfunction

  function automatic joy_item_t random_item(int tick_pct);
    joy_item_t it;
    int        span;
    it.cmd     = ($urandom_range(99) < tick_pct) ? CMD_TICK : CMD_SAMPLE;
    it.accel_z = ($urandom_range(9) == 0) ? BAD_ACCEL : pulse_t'($urandom);
    case ($urandom_range(9))
      0:       it.buttons = BTN_C_ONLY;
      1, 2:    it.buttons = BTN_Z_ONLY;
      3:       it.buttons = BTN_BOTH;
      default: it.buttons = BTN_NONE;
    endcase
    // a third of the samples sit around the zero point to hit the deadband edge
    if ($urandom_range(2) == 0) begin
      span = 2 * int'(shadow_cfg.deadband) + 2;
      it.stick_x = near_home(home_x, span);
      it.stick_y = near_home(home_y, span);
    end else begin
      it.stick_x = pulse_t'($urandom);
      it.stick_y = pulse_t'($urandom);
    end
    return it;
  endfunction

  // in_valid stays high after a transfer; the next call idles or drives again
  task automatic send_item(joy_item_t it);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= it.cmd;
    in_stick_x <= it.stick_x;
    in_stick_y <= it.stick_y;
    in_accel_z <= it.accel_z;
    in_buttons <= it.buttons;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_wheel_state.push_back(predict_wheel_state(it));
  endtask

  task automatic send_sample(pulse_t sx, pulse_t sy, pulse_t az, logic [1:0] btn);
    joy_item_t it;
    it = '{cmd: CMD_SAMPLE, stick_x: sx, stick_y: sy, accel_z: az, buttons: btn};
    send_item(it);
  endtask

  task automatic send_tick();
    joy_item_t it;
    it = '{cmd: CMD_TICK, stick_x: pulse_t'($urandom), stick_y: pulse_t'($urandom),
           accel_z: pulse_t'($urandom), buttons: 2'($urandom)};
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_wheel_state.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_we is left high; apply_config lowers it after the last write
  task automatic write_reg(logic [2:0] idx, logic [10:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_DEADBAND:  shadow_cfg.deadband     = data[DB_W-1:0];
      REG_PULSE_MIN: shadow_cfg.pulse_min    = data[7:0];
      REG_PULSE_MAX: shadow_cfg.pulse_max    = data[7:0];
      REG_CENTRE:    shadow_cfg.centre_pulse = data[7:0];
      REG_GAP_TICKS: shadow_cfg.gap_ticks    = data[GAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(cfg_t settings);
    wait_drained();
    write_reg(REG_DEADBAND, {4'($urandom), settings.deadband});
    write_reg(REG_PULSE_MIN, {3'($urandom), settings.pulse_min});
    write_reg(REG_PULSE_MAX, {3'($urandom), settings.pulse_max});
    write_reg(REG_CENTRE, {3'($urandom), settings.centre_pulse});
    write_reg(REG_GAP_TICKS, settings.gap_ticks);
    // unmapped indexes must leave every register alone
    for (int i = int'(REG_GAP_TICKS) + 1; i < 2 ** $bits(cfg_index); i++) begin
      write_reg(3'(i), 11'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(cfg_t settings, int items, int tick_pct, bit quiet);
    apply_config(settings);
    steady_flow = quiet;
    for (int n = 0; n < items; n++) begin
      if (n == items / 2) wait_drained();
      send_item(random_item(tick_pct));
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_idle_before_start();
    send_tick();
    send_sample(8'd255, 8'd0, 8'd0, BTN_NONE);
    send_sample(8'd0, 8'd255, 8'd17, BTN_Z_ONLY);
    send_sample(8'd200, 8'd40, 8'd0, BTN_BOTH);
    // a bad accel byte does not block the start
    send_sample(8'd128, 8'd128, BAD_ACCEL, BTN_C_ONLY);
  endtask

  task automatic test_mixing_modes();
    send_sample(8'd255, 8'd255, 8'd0, BTN_NONE);
    send_sample(8'd0, 8'd0, 8'd0, BTN_NONE);
    send_sample(8'd129, 8'd127, 8'd0, BTN_NONE);
    send_sample(8'd147, 8'd128, 8'd0, BTN_NONE);
    send_sample(8'd148, 8'd128, 8'd0, BTN_NONE);
    send_sample(8'd200, 8'd128, 8'd0, BTN_Z_ONLY);
    send_sample(8'd60, 8'd200, 8'd0, BTN_BOTH);
    send_sample(8'd0, 8'd0, BAD_ACCEL, BTN_NONE);
    send_sample(8'd10, 8'd250, 8'd0, BTN_C_ONLY);
    send_sample(8'd255, 8'd0, 8'd0, BTN_NONE);
    send_sample(8'd10, 8'd250, BAD_ACCEL, BTN_Z_ONLY);
    repeat (3) send_tick();
  endtask

  task automatic test_sequencer_fast();
    run_phase('{deadband: 7'd3, pulse_min: 8'd2, pulse_max: 8'd20,
                centre_pulse: 8'd8, gap_ticks: 11'd5}, 500, 70, 1'b0);
  endtask

  task automatic test_low_extremes();
    run_phase('{deadband: 7'd0, pulse_min: 8'd0, pulse_max: 8'd255,
                centre_pulse: 8'd0, gap_ticks: 11'd1}, 350, 50, 1'b1);
  endtask

  task automatic test_random_settings();
    cfg_t pick;
    repeat (4) begin
      pick.deadband     = 7'($urandom_range(12));
      pick.pulse_min    = pulse_t'($urandom_range(30));
      pick.pulse_max    = pulse_t'($urandom_range(70));
      pick.centre_pulse = pulse_t'($urandom_range(60));
      pick.gap_ticks    = 11'($urandom_range(40, 1));
      run_phase(pick, 150, 60, 1'b0);
    end
  endtask

  task automatic test_crossed_bounds();
    run_phase('{deadband: 7'd127, pulse_min: 8'd255, pulse_max: 8'd0,
                centre_pulse: 8'd255, gap_ticks: 11'd2047}, 150, 40, 1'b0);
  endtask

  task automatic test_reset_values();
    run_phase(CFG_RESET, 250, 50, 1'b0);
  endtask

  always @(posedge clk) begin
    out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    wheel_state_t want;
    logic         bad;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_wheel_state.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: transfer with nothing expected, pins %b running %b",
                   $realtime, out_servo_pins, out_running);
        end
      end else begin
        want = expected_wheel_state.pop_front();
        bad  = 1'b0;
        if (out_servo_pins !== want.pins) bad = 1'b1;
        if (out_wheel0_pulse !== want.wheels[0]) bad = 1'b1;
        if (out_wheel1_pulse !== want.wheels[1]) bad = 1'b1;
        if (out_wheel2_pulse !== want.wheels[2]) bad = 1'b1;
        if (out_wheel3_pulse !== want.wheels[3]) bad = 1'b1;
        if (out_running !== want.running) bad = 1'b1;
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch (expected/actual) pins %b/%b run %b/%b", $realtime,
                     want.pins, out_servo_pins, want.running, out_running);
            $display("  wheels %0d/%0d %0d/%0d %0d/%0d %0d/%0d",
                     want.wheels[0], out_wheel0_pulse, want.wheels[1], out_wheel1_pulse,
                     want.wheels[2], out_wheel2_pulse, want.wheels[3], out_wheel3_pulse);
          end
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_before_start();
    test_mixing_modes();
    test_sequencer_fast();
    test_low_extremes();
    test_random_settings();
    test_crossed_bounds();
    test_reset_values();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
